// ----- design/bdq_pkg.sv -----
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int DATA_W     = 32;
  localparam int CAP_W      = 11;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;
  localparam int DEPTH_DEF  = 1024;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_LEFT  = 2'd0,
    OP_PUSH_RIGHT = 2'd1,
    OP_POP_LEFT   = 2'd2,
    OP_POP_RIGHT  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSH_LEFT  = 3'd0,
    ST_PUSH_RIGHT = 3'd1,
    ST_POP_LEFT   = 3'd2,
    ST_POP_RIGHT  = 3'd3,
    ST_FULL       = 3'd4,
    ST_EMPTY      = 3'd5
  } status_t;

  // per-cell update select
  typedef struct packed {
    logic shift_up;    // take word from lower neighbor
    logic shift_down;  // take word from upper neighbor
    logic load;        // take inserted word
  } bdq_cell_ctrl_t;

  // chain-wide update command
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic load_en;     // load at load_idx only
  } bdq_chain_ctrl_t;

endpackage

// ----- design/bdq_cell.sv -----
`timescale 1ns / 1ps

module bdq_cell (
  input  logic                          clk,
  input  bdq_pkg::bdq_cell_ctrl_t       ctrl,
  input  logic [bdq_pkg::DATA_W-1:0]    lower_word,
  input  logic [bdq_pkg::DATA_W-1:0]    upper_word,
  input  logic [bdq_pkg::DATA_W-1:0]    din,
  output logic [bdq_pkg::DATA_W-1:0]    q
);

  logic [bdq_pkg::DATA_W-1:0] word_r;
  logic [bdq_pkg::DATA_W-1:0] word_nxt;

  always_comb begin
    priority if (ctrl.shift_up) begin
      word_nxt = lower_word;
    end else if (ctrl.shift_down) begin
      word_nxt = upper_word;
    end else if (ctrl.load) begin
      word_nxt = din;
    end else begin
      word_nxt = word_r;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q = word_r;

endmodule

// ----- design/bdq_chain.sv -----
`timescale 1ns / 1ps

// Row of cells; cell 0 is the end word of the deque for this chain.
module bdq_chain #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  bdq_pkg::bdq_chain_ctrl_t      ctrl,
  input  logic [IDX_W-1:0]              load_idx,
  input  logic [bdq_pkg::DATA_W-1:0]    din,
  output logic [bdq_pkg::DATA_W-1:0]    end_word
);

  logic [bdq_pkg::DATA_W-1:0] q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [bdq_pkg::DATA_W-1:0] lower_word;
    logic [bdq_pkg::DATA_W-1:0] upper_word;
    bdq_pkg::bdq_cell_ctrl_t    cell_ctrl;

    if (i == 0) begin : g_lo
      assign lower_word = din;
    end else begin : g_lo
      assign lower_word = q[i-1];
    end

    if (i == DEPTH - 1) begin : g_hi
      assign upper_word = din;  // don't care, slot leaves the deque
    end else begin : g_hi
      assign upper_word = q[i+1];
    end

    assign cell_ctrl.shift_up   = ctrl.shift_up;
    assign cell_ctrl.shift_down = ctrl.shift_down;
    assign cell_ctrl.load       = ctrl.load_en && (load_idx == IDX_W'(i));

    bdq_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .lower_word (lower_word),
      .upper_word (upper_word),
      .din        (din),
      .q          (q[i])
    );
  end

  assign end_word = q[0];

endmodule

// ----- design/bounded_double_ended_queue.sv -----
`timescale 1ns / 1ps
// Result: a result word is registered and valid in the cycle after its operation is accepted.
// Throughput: one operation per cycle; each op is a single parallel update of the
//   two cell chains, and the input stalls only while a result waits under out_stall.
// Reset (sync, active low): occupancy zero, capacity 1024, output register empty.
//   Stored words are not cleared; they are only read after being written.

module bounded_double_ended_queue #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // operation words
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bdq_pkg::OP_W-1:0]           in_opcode,
  input  logic signed [bdq_pkg::DATA_W-1:0]  in_push_value,
  // result words
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bdq_pkg::STATUS_W-1:0]       out_status,
  output logic signed [bdq_pkg::DATA_W-1:0]  out_result_value,
  // capacity register
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bdq_pkg::CAP_W-1:0]          cfg_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > bdq_pkg::CAP_W) ? CNT_W : bdq_pkg::CAP_W;

  // Two copies of the contents. Chain A keeps the leftmost word in cell 0,
  // chain B keeps the rightmost word in cell 0. Pushes at a chain's own end
  // shift it up; pushes at the far end load the cell at the occupancy index.
  // Pops at a chain's own end shift it down; pops at the far end just drop
  // the top word by lowering the count. Both pop reads are from cell 0.

  logic [bdq_pkg::CAP_W-1:0]   capacity_r;
  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            count_nxt;
  logic                        out_valid_r;
  bdq_pkg::status_t            out_status_r;
  logic [bdq_pkg::DATA_W-1:0]  out_value_r;

  logic                        accept;
  logic                        take_out;
  logic [CMP_W-1:0]            cap_ext;
  logic [CMP_W-1:0]            depth_ext;
  logic [CMP_W-1:0]            cap_eff;
  logic                        full;
  logic                        empty;
  bdq_pkg::op_t                op;
  bdq_pkg::status_t            status;
  logic [bdq_pkg::DATA_W-1:0]  value;
  logic                        do_op;
  logic                        is_push;
  bdq_pkg::bdq_chain_ctrl_t    a_ctrl;
  bdq_pkg::bdq_chain_ctrl_t    b_ctrl;
  logic [IDX_W-1:0]            load_idx;
  logic [bdq_pkg::DATA_W-1:0]  a_end;
  logic [bdq_pkg::DATA_W-1:0]  b_end;

  // handshakes
  assign cfg_ready = 1'b1;
  assign take_out  = out_valid_r && !out_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;

  // capacity clamps at DEPTH
  assign cap_ext   = CMP_W'(capacity_r);
  assign depth_ext = CMP_W'(DEPTH);
  assign cap_eff   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
  assign full      = CMP_W'(count_r) >= cap_eff;
  assign empty     = (count_r == '0);

  assign op       = bdq_pkg::op_t'(in_opcode);
  assign is_push  = (op == bdq_pkg::OP_PUSH_LEFT) || (op == bdq_pkg::OP_PUSH_RIGHT);
  assign do_op    = accept && (is_push ? !full : !empty);
  // a successful push has count below DEPTH, so it fits the index
  assign load_idx = IDX_W'(count_r);

  always_comb begin
    a_ctrl = '0;
    b_ctrl = '0;
    status = bdq_pkg::ST_EMPTY;
    value  = '0;
    unique case (op)
      bdq_pkg::OP_PUSH_LEFT: begin
        status           = full ? bdq_pkg::ST_FULL : bdq_pkg::ST_PUSH_LEFT;
        value            = full ? '0 : in_push_value;
        a_ctrl.shift_up  = do_op;
        b_ctrl.load_en   = do_op;
      end
      bdq_pkg::OP_PUSH_RIGHT: begin
        status           = full ? bdq_pkg::ST_FULL : bdq_pkg::ST_PUSH_RIGHT;
        value            = full ? '0 : in_push_value;
        a_ctrl.load_en   = do_op;
        b_ctrl.shift_up  = do_op;
      end
      bdq_pkg::OP_POP_LEFT: begin
        status            = empty ? bdq_pkg::ST_EMPTY : bdq_pkg::ST_POP_LEFT;
        value             = empty ? '0 : a_end;
        a_ctrl.shift_down = do_op;
      end
      bdq_pkg::OP_POP_RIGHT: begin
        status            = empty ? bdq_pkg::ST_EMPTY : bdq_pkg::ST_POP_RIGHT;
        value             = empty ? '0 : b_end;
        b_ctrl.shift_down = do_op;
      end
      default: begin
        status = bdq_pkg::ST_EMPTY;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (do_op) begin
      count_nxt = is_push ? count_r + 1'b1 : count_r - 1'b1;
    end
  end

  bdq_chain #(.DEPTH(DEPTH)) u_chain_a (
    .clk      (clk),
    .ctrl     (a_ctrl),
    .load_idx (load_idx),
    .din      (in_push_value),
    .end_word (a_end)
  );

  bdq_chain #(.DEPTH(DEPTH)) u_chain_b (
    .clk      (clk),
    .ctrl     (b_ctrl),
    .load_idx (load_idx),
    .din      (in_push_value),
    .end_word (b_end)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= bdq_pkg::CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_data;
      end
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (take_out) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status;
      out_value_r  <= value;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;

  // occupancy never passes the store size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= depth_ext)
    else $error("occupancy above depth");

  // a successful push raises occupancy by one
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_op && is_push) |=> (count_r == $past(count_r) + 1'b1))
    else $error("push did not bump occupancy");

  // refused operations carry a zero value
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((out_status_r == bdq_pkg::ST_FULL) ||
                     (out_status_r == bdq_pkg::ST_EMPTY))) |-> (out_value_r == '0))
    else $error("refused result with nonzero value");

  // input held back only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty output register");

endmodule
